### design/small_key_value_table_macros.svh
// assertion macros for the small key/value table
// used by the top level; no other dependencies
`ifndef SMALL_KEY_VALUE_TABLE_MACROS_SVH
`define SMALL_KEY_VALUE_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define SKVT_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define SKVT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SKVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SKVT_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define SKVT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define SKVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/skvt_pkg.sv
// shared types and defaults for the small key/value table
// no dependencies
package skvt_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int KEY_BITS_DEF   = 16;
  localparam int VALUE_BITS_DEF = 16;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_ABSENT    = 2'd3
  } status_t;

  // control part of the operation token walking the cell chain
  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  hit;
    logic  placed;
    logic  hole;
  } tok_ctrl_t;

endpackage

### design/skvt_cell.sv
// one slot of the table: holds a key/value pair and passes the operation token on
// depends on skvt_pkg
module skvt_cell #(
  parameter int CAPACITY   = skvt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = skvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = skvt_pkg::VALUE_BITS_DEF,
  localparam int CW        = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  skvt_pkg::tok_ctrl_t   tok_in,
  input  logic [KEY_BITS-1:0]   tok_in_key,
  input  logic [VALUE_BITS-1:0] tok_in_value,
  input  logic [VALUE_BITS-1:0] tok_in_hval,
  input  logic [CW-1:0]         tok_in_left,
  output skvt_pkg::tok_ctrl_t   tok_out,
  output logic [KEY_BITS-1:0]   tok_out_key,
  output logic [VALUE_BITS-1:0] tok_out_value,
  output logic [VALUE_BITS-1:0] tok_out_hval,
  output logic [CW-1:0]         tok_out_left,
  input  logic                  pull_in,
  input  logic [KEY_BITS-1:0]   up_key,
  input  logic [VALUE_BITS-1:0] up_value,
  output logic                  pull_out,
  output logic [KEY_BITS-1:0]   slot_key,
  output logic [VALUE_BITS-1:0] slot_value
);
  import skvt_pkg::*;

  tok_ctrl_t             tok_r;
  logic [KEY_BITS-1:0]   tok_key_r;
  logic [VALUE_BITS-1:0] tok_value_r;
  logic [VALUE_BITS-1:0] tok_hval_r;
  logic [CW-1:0]         tok_left_r;
  logic [KEY_BITS-1:0]   slot_key_r;
  logic [VALUE_BITS-1:0] slot_value_r;

  logic slot_used;
  logic match;
  logic do_ins;

  // slots below the live count are the ones in use
  assign slot_used = (tok_left_r != '0);
  assign match     = tok_r.valid && slot_used && !tok_r.hit && (slot_key_r == tok_key_r);
  assign do_ins    = tok_r.valid && (tok_r.kind == KIND_INSERT) && !slot_used
                     && !tok_r.hit && !tok_r.placed;
  // a hole below: the lower neighbor takes this slot
  assign pull_out  = tok_r.valid && tok_r.hole && slot_used;

  always_comb begin
    tok_out = tok_r;
    if (match) begin
      tok_out.hit  = 1'b1;
      tok_out.hole = (tok_r.kind == KIND_DELETE);
    end
    if (do_ins) begin
      tok_out.placed = 1'b1;
    end
  end

  assign tok_out_key   = tok_key_r;
  assign tok_out_value = tok_value_r;
  assign tok_out_hval  = match ? slot_value_r : tok_hval_r;
  assign tok_out_left  = slot_used ? tok_left_r - CW'(1) : tok_left_r;
  assign slot_key      = slot_key_r;
  assign slot_value    = slot_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_key_r   <= tok_in_key;
    tok_value_r <= tok_in_value;
    tok_hval_r  <= tok_in_hval;
    tok_left_r  <= tok_in_left;
    if (pull_in) begin
      slot_key_r   <= up_key;
      slot_value_r <= up_value;
    end else if (do_ins) begin
      slot_key_r   <= tok_key_r;
      slot_value_r <= tok_value_r;
    end
  end

endmodule

### design/small_key_value_table.sv
// Small key/value table with lookup, insert and delete.
// Channels: in_* carries one operation item (in_kind, in_key, in_value) under
// in_valid/in_ready; out_* returns one result item per operation under
// out_valid/out_ready.
// The table is a chain of CAPACITY slot cells. An accepted item becomes a
// token that visits one cell per cycle, comparing keys, appending at the
// first unused slot, or opening a hole on delete that the following cells
// close by handing their pair down to the lower neighbor.
// Items are taken one at a time: in_ready stays low from the accept while the
// token walks the chain and until its result is handed to the output register.
// A result waiting in the output register does not block the next item;
// a second finished result waits in a hold register, and in_ready stays low
// until that result moves to the output register.
// Reset (synchronous, rst_n low) empties the table and holds
// in_ready low; slot contents are not cleared, only the entry count.
// depends on skvt_pkg, skvt_cell and small_key_value_table_macros.svh
`include "small_key_value_table_macros.svh"

module small_key_value_table #(
  parameter int CAPACITY   = skvt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = skvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = skvt_pkg::VALUE_BITS_DEF,
  localparam int CW        = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [VALUE_BITS-1:0] out_read_value,
  output logic [1:0]            out_status,
  output logic [CW-1:0]         out_entries_used,
  output logic                  out_is_empty,
  output logic                  out_is_full
);
  import skvt_pkg::*;

  tok_ctrl_t             chain_ctrl  [0:CAPACITY];
  logic [KEY_BITS-1:0]   chain_key   [0:CAPACITY];
  logic [VALUE_BITS-1:0] chain_value [0:CAPACITY];
  logic [VALUE_BITS-1:0] chain_hval  [0:CAPACITY];
  logic [CW-1:0]         chain_left  [0:CAPACITY];
  logic                  pull        [0:CAPACITY];
  logic [KEY_BITS-1:0]   slot_key    [0:CAPACITY];
  logic [VALUE_BITS-1:0] slot_value  [0:CAPACITY];
  logic [CAPACITY-1:0]   tok_at;

  logic [CW-1:0]         used_count_r, used_count_nxt;
  logic                  busy_r;
  logic                  fin_valid_r;
  logic                  fin_found_r;
  logic [VALUE_BITS-1:0] fin_value_r;
  status_t               fin_status_r;
  logic [CW-1:0]         fin_count_r;
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [VALUE_BITS-1:0] out_value_r;
  status_t               out_status_r;
  logic [CW-1:0]         out_count_r;

  logic                  in_accept;
  logic                  exit_valid;
  logic                  out_load;
  status_t               res_status;
  tok_ctrl_t             tok_head;

  assign in_ready   = rst_n && !busy_r;
  assign in_accept  = in_valid && in_ready;
  assign exit_valid = chain_ctrl[CAPACITY].valid;
  assign out_load   = fin_valid_r && (!out_valid_r || out_ready);

  always_comb begin
    tok_head        = '0;
    tok_head.valid  = in_accept;
    tok_head.kind   = kind_t'(in_kind);
  end

  assign chain_ctrl[0]  = tok_head;
  assign chain_key[0]   = in_key;
  assign chain_value[0] = in_value;
  assign chain_hval[0]  = '0;
  assign chain_left[0]  = used_count_r;

  // nothing above the top cell
  assign pull[CAPACITY]       = 1'b0;
  assign slot_key[CAPACITY]   = '0;
  assign slot_value[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skvt_cell #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .tok_in        (chain_ctrl[i]),
      .tok_in_key    (chain_key[i]),
      .tok_in_value  (chain_value[i]),
      .tok_in_hval   (chain_hval[i]),
      .tok_in_left   (chain_left[i]),
      .tok_out       (chain_ctrl[i+1]),
      .tok_out_key   (chain_key[i+1]),
      .tok_out_value (chain_value[i+1]),
      .tok_out_hval  (chain_hval[i+1]),
      .tok_out_left  (chain_left[i+1]),
      .pull_in       (pull[i+1]),
      .up_key        (slot_key[i+1]),
      .up_value      (slot_value[i+1]),
      .pull_out      (pull[i]),
      .slot_key      (slot_key[i]),
      .slot_value    (slot_value[i])
    );
    assign tok_at[i] = chain_ctrl[i+1].valid;
  end

  // result of the token leaving the top cell
  always_comb begin
    used_count_nxt = used_count_r;
    unique case (chain_ctrl[CAPACITY].kind)
      KIND_INSERT: begin
        if (chain_ctrl[CAPACITY].hit) begin
          res_status = ST_DUPLICATE;
        end else if (chain_ctrl[CAPACITY].placed) begin
          res_status     = ST_DONE;
          used_count_nxt = used_count_r + CW'(1);
        end else begin
          res_status = ST_FULL;
        end
      end
      KIND_DELETE: begin
        if (chain_ctrl[CAPACITY].hit) begin
          res_status     = ST_DONE;
          used_count_nxt = used_count_r - CW'(1);
        end else begin
          res_status = ST_ABSENT;
        end
      end
      default: begin
        res_status = chain_ctrl[CAPACITY].hit ? ST_DONE : ST_ABSENT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_count_r <= '0;
      busy_r       <= 1'b0;
      fin_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        busy_r <= 1'b1;
      end
      if (exit_valid) begin
        fin_valid_r  <= 1'b1;
        used_count_r <= used_count_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        fin_valid_r <= 1'b0;
        busy_r      <= 1'b0;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exit_valid) begin
      fin_found_r  <= chain_ctrl[CAPACITY].hit;
      fin_value_r  <= chain_ctrl[CAPACITY].hit ? chain_hval[CAPACITY] : '0;
      fin_status_r <= res_status;
      fin_count_r  <= used_count_nxt;
    end
    if (out_load) begin
      out_found_r  <= fin_found_r;
      out_value_r  <= fin_value_r;
      out_status_r <= fin_status_r;
      out_count_r  <= fin_count_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_read_value   = out_value_r;
  assign out_status       = out_status_r;
  assign out_entries_used = out_count_r;
  assign out_is_empty     = (out_count_r == '0);
  assign out_is_full      = (out_count_r == CW'(CAPACITY));

  `SKVT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, used_count_r <= CW'(CAPACITY))
  `SKVT_ASSERT_ALWAYS(a_one_token, clk, rst_n, $onehot0(tok_at))
  `SKVT_ASSERT_IMPLIES(a_idle_no_token, clk, rst_n, !busy_r, tok_at == '0)
  `SKVT_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_accept, tok_at[0])
  `SKVT_ASSERT_IMPLIES(a_fin_busy, clk, rst_n, fin_valid_r, busy_r && (tok_at == '0))

endmodule
